// ===== rtl/ab5v_pkg.sv =====
// Shared constants and types for the fifth-order Adams-Bashforth vector step.
`default_nettype none

package ab5v_pkg;

	localparam int POINTS_DEF    = 4096;
	localparam int WORD_BITS_DEF = 32;
	localparam int IDX_BITS      = 12;
	localparam int DT_BITS       = 32;
	localparam int GAIN_BITS     = 17;
	localparam int GAIN_RESET    = 65536;
	localparam int CFG_BITS      = 32;
	localparam int CFG_IDX_BITS  = 1;

	// Register stages from input capture to output register.
	localparam int STAGES = 11;

	// Step weights, all over 720.
	localparam int C_D0 = 1901;
	localparam int C_H1 = 2774;
	localparam int C_H2 = 2616;
	localparam int C_H3 = 1274;
	localparam int C_H4 = 251;

	// Divide by 720 * 2^16 = 45 * 2^20, with half of the divisor added for rounding.
	localparam int ROUND_ADD = 360 * 65536;
	localparam int DIV_SHIFT = 20;
	localparam int DIV_ODD   = 45;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_DT_STEP = 1'b0,
		REG_DAMPING = 1'b1
	} cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/ab5v_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ab5v_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ab5v_lane.sv =====
// One vector component: weighted derivative sum, dt and damping scaling, saturating add.
`default_nettype none

module ab5v_lane #(
	parameter int W = ab5v_pkg::WORD_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             adv,
	input  wire logic                             upd,
	input  wire logic [ab5v_pkg::DT_BITS-1:0]     dt,
	input  wire logic [ab5v_pkg::GAIN_BITS-1:0]   gain,
	input  wire logic signed [W-1:0]              value,
	input  wire logic signed [W-1:0]              d0,
	input  wire logic signed [W-1:0]              h1,
	input  wire logic signed [W-1:0]              h2,
	input  wire logic signed [W-1:0]              h3,
	input  wire logic signed [W-1:0]              h4,
	output logic signed [W-1:0]                   result
);

	localparam int LAST = ab5v_pkg::STAGES;
	localparam int DTB  = ab5v_pkg::DT_BITS;
	localparam int GB   = ab5v_pkg::GAIN_BITS;
	localparam int SW   = W + 14;
	localparam int MW   = W + 13;
	localparam int ML   = (MW + 1) / 2;
	localparam int MH   = MW - ML;
	localparam int PW   = MW + DTB;
	localparam int BW   = (MW + GB > 64) ? 64 : MW + GB;
	localparam int BKW  = (BW + 1 > 64) ? 64 : BW + 1;
	localparam int TW   = BKW - ab5v_pkg::DIV_SHIFT;
	localparam int RS   = TW + 6;
	localparam int RW   = RS - 5;
	localparam int TL   = (TW + 1) / 2;
	localparam int TH   = TW - TL;
	localparam int QW   = TW + RW;
	localparam int CW   = TW - 5;
	localparam int XW   = ((CW > W) ? CW : W) + 2;

	localparam logic signed [SW-1:0] K_D0 = SW'(ab5v_pkg::C_D0);
	localparam logic signed [SW-1:0] K_H1 = SW'(ab5v_pkg::C_H1);
	localparam logic signed [SW-1:0] K_H2 = SW'(ab5v_pkg::C_H2);
	localparam logic signed [SW-1:0] K_H3 = SW'(ab5v_pkg::C_H3);
	localparam logic signed [SW-1:0] K_H4 = SW'(ab5v_pkg::C_H4);
	localparam logic [PW-1:0]  HALF  = {{MW{1'b0}}, 1'b1, {(DTB-1){1'b0}}};
	localparam logic [BKW-1:0] RADD  = BKW'(ab5v_pkg::ROUND_ADD);
	// Reciprocal of 45 scaled by 2^RS, rounded up; exact for every dividend of TW bits.
	localparam logic [63:0]    RECIP64 = ((64'd1 << RS) + 64'(ab5v_pkg::DIV_ODD - 1))
		/ 64'(ab5v_pkg::DIV_ODD);
	localparam logic [RW-1:0]  RECIP = RECIP64[RW-1:0];
	localparam logic signed [XW-1:0] MAXV = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [XW-1:0] MINV = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};

	logic signed [SW-1:0] d0_x, h1_x, h2_x, h3_x, h4_x;
	logic signed [SW-1:0] pa_s2, pb_s2;
	logic signed [SW-1:0] sum_s3;
	logic signed [SW-1:0] abs_s3;
	logic [MW-1:0]        m_s4;
	logic [ML+DTB-1:0]    pl_s5;
	logic [MH+DTB-1:0]    ph_s5;
	logic [PW-1:0]        acc_s5;
	logic [MW-1:0]        a_s6;
	logic [MW+GB-1:0]     prod_s6;
	logic [BW-1:0]        b_s7;
	logic [BKW-1:0]       bk_s7;
	logic [TW-1:0]        t_s8;
	logic [TL+RW-1:0]     ql_s9;
	logic [TH+RW-1:0]     qh_s9;
	logic [QW-1:0]        qs_s9;
	logic [CW-1:0]        c_s10;
	logic signed [XW-1:0] cx_s10, vx_s10, r_s10;
	logic signed [W-1:0]  val_s [2:LAST-1];
	logic                 upd_s [2:LAST-1];
	logic                 neg_s [4:LAST-1];

	assign d0_x = {{(SW-W){d0[W-1]}}, d0};
	assign h1_x = {{(SW-W){h1[W-1]}}, h1};
	assign h2_x = {{(SW-W){h2[W-1]}}, h2};
	assign h3_x = {{(SW-W){h3[W-1]}}, h3};
	assign h4_x = {{(SW-W){h4[W-1]}}, h4};

	assign abs_s3  = sum_s3[SW-1] ? -sum_s3 : sum_s3;
	assign acc_s5  = {ph_s5, {ML{1'b0}}} + PW'(pl_s5) + HALF;
	assign prod_s6 = a_s6 * gain;
	assign bk_s7   = BKW'(b_s7) + RADD;
	assign qs_s9   = {qh_s9, {TL{1'b0}}} + QW'(ql_s9);

	assign cx_s10 = {{(XW-CW){1'b0}}, c_s10};
	assign vx_s10 = {{(XW-W){val_s[LAST-1][W-1]}}, val_s[LAST-1]};
	assign r_s10  = vx_s10 + (neg_s[LAST-1] ? -cx_s10 : cx_s10);

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s2   <= K_D0 * d0_x - K_H1 * h1_x;
			pb_s2   <= K_H2 * h2_x - K_H3 * h3_x + K_H4 * h4_x;
			sum_s3  <= pa_s2 + pb_s2;
			m_s4    <= abs_s3[MW-1:0];
			pl_s5   <= m_s4[ML-1:0] * dt;
			ph_s5   <= m_s4[MW-1:ML] * dt;
			a_s6    <= acc_s5[PW-1:DTB];
			b_s7    <= prod_s6[BW-1:0];
			t_s8    <= bk_s7[BKW-1:ab5v_pkg::DIV_SHIFT];
			ql_s9   <= t_s8[TL-1:0] * RECIP;
			qh_s9   <= t_s8[TW-1:TL] * RECIP;
			c_s10   <= qs_s9[QW-1:RS];

			val_s[2] <= value;
			upd_s[2] <= upd;
			for (int i = 3; i < LAST; i++) begin
				val_s[i] <= val_s[i-1];
				upd_s[i] <= upd_s[i-1];
			end
			neg_s[4] <= sum_s3[SW-1];
			for (int i = 5; i < LAST; i++) begin
				neg_s[i] <= neg_s[i-1];
			end

			// Inactive items pass the value through untouched.
			if (!upd_s[LAST-1]) begin
				result <= val_s[LAST-1];
			end else if (r_s10 > MAXV) begin
				result <= MAXV[W-1:0];
			end else if (r_s10 < MINV) begin
				result <= MINV[W-1:0];
			end else begin
				result <= r_s10[W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/adams_bashforth5_vector_step.sv =====
// Top level: stream ports, config registers, history memory with forwarding, three lanes.
`default_nettype none

// Fifth-order Adams-Bashforth integrator for 3-vectors, one point per beat. Each input beat
// carries a point index, its current value and new derivative; the output beat carries the
// updated value, saturated to the word width (an inactive beat, or one whose index is not
// below POINTS, passes its value through unchanged). The pipeline is 11 register stages
// deep and takes a new beat every cycle unless the output stalls or the sweep runs. When the
// output beat is not taken the whole pipeline holds. The per-point derivative history lives
// in one RAM of POINTS entries, read as the beat enters and written back one stage later; a
// back-to-back update of the same point is forwarded around the RAM. After reset the RAM is
// swept to zero, one entry per cycle, and s_tready stays low until the sweep is done;
// configuration writes are taken during that time.
module adams_bashforth5_vector_step #(
	parameter int POINTS    = ab5v_pkg::POINTS_DEF,
	parameter int WORD_BITS = ab5v_pkg::WORD_BITS_DEF,
	localparam int IN_W  = ((ab5v_pkg::IDX_BITS + 6 * WORD_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((ab5v_pkg::IDX_BITS + 3 * WORD_BITS + 7) / 8) * 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [ab5v_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [ab5v_pkg::CFG_BITS-1:0]     cfg_data,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// point_index, value_x, value_y, value_z, deriv_x, deriv_y, deriv_z, zero pad
	input  wire logic [IN_W-1:0]                   s_tdata,
	// active
	input  wire logic [0:0]                        s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// out_index, new_x, new_y, new_z, zero pad
	output logic [OUT_W-1:0]                       m_tdata
);

	localparam int W    = WORD_BITS;
	localparam int IB   = ab5v_pkg::IDX_BITS;
	localparam int AW   = (POINTS > 1) ? $clog2(POINTS) : 1;
	localparam int VW   = 3 * W;
	localparam int HW   = 4 * VW;
	localparam int LAST = ab5v_pkg::STAGES;

	logic                                 adv;
	logic                                 in_acc;
	logic [IB-1:0]                        in_idx;
	logic [AW-1:0]                        in_addr;
	logic                                 in_upd;

	logic [LAST:1]                        vld_s;
	logic [IB-1:0]                        idx_s [1:LAST];
	logic                                 upd_s1;
	logic [AW-1:0]                        addr_s1;
	logic [VW-1:0]                        val_s1;
	logic [VW-1:0]                        der_s1;
	logic                                 fwd_s1;
	logic [HW-1:0]                        fwd_hist_s1;

	logic                                 clr_q;
	logic [AW-1:0]                        clr_addr_q;
	logic [ab5v_pkg::DT_BITS-1:0]         dt_q;
	logic [ab5v_pkg::GAIN_BITS-1:0]       gain_q;

	logic [HW-1:0]                        ram_rdata;
	logic [HW-1:0]                        hist_rd;
	logic [HW-1:0]                        hist_new;
	logic                                 item_we;
	logic                                 hist_we;
	logic [AW-1:0]                        hist_waddr;
	logic [HW-1:0]                        hist_wdata;
	logic signed [W-1:0]                  res [3];

	assign adv      = !vld_s[LAST] || m_tready;
	assign s_tready = adv && !clr_q;
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = vld_s[LAST];

	assign in_idx  = s_tdata[IB-1:0];
	assign in_addr = AW'(in_idx);
	assign in_upd  = s_tuser[0] && (32'(in_idx) < 32'(POINTS));

	// Control state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s      <= '0;
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			dt_q       <= '0;
			gain_q     <= ab5v_pkg::GAIN_BITS'(ab5v_pkg::GAIN_RESET);
		end else begin
			if (adv) begin
				vld_s <= {vld_s[LAST-1:1], in_acc};
			end
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(POINTS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (cfg_wr_en) begin
				unique case (ab5v_pkg::cfg_reg_t'(cfg_index))
					ab5v_pkg::REG_DT_STEP: begin
						dt_q <= cfg_data[ab5v_pkg::DT_BITS-1:0];
					end
					ab5v_pkg::REG_DAMPING: begin
						gain_q <= cfg_data[ab5v_pkg::GAIN_BITS-1:0];
					end
				endcase
			end
		end
	end

	// Payload capture and index delay line.
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s[1]    <= in_idx;
			upd_s1      <= in_upd;
			addr_s1     <= in_addr;
			val_s1      <= s_tdata[IB +: VW];
			der_s1      <= s_tdata[IB+VW +: VW];
			// Catch a history write to the same point on this very edge.
			fwd_s1      <= hist_we && (hist_waddr == in_addr);
			fwd_hist_s1 <= hist_wdata;
			for (int i = 2; i <= LAST; i++) begin
				idx_s[i] <= idx_s[i-1];
			end
		end
	end

	assign hist_rd  = fwd_s1 ? fwd_hist_s1 : ram_rdata;
	// Shift history: newest derivative into slot one, oldest drops out.
	assign hist_new = {hist_rd[HW-VW-1:0], der_s1};
	assign item_we  = adv && vld_s[1] && upd_s1;

	always_comb begin
		if (clr_q) begin
			hist_we    = 1'b1;
			hist_waddr = clr_addr_q;
			hist_wdata = '0;
		end else begin
			hist_we    = item_we;
			hist_waddr = addr_s1;
			hist_wdata = hist_new;
		end
	end

	ab5v_ram #(
		.WIDTH (HW),
		.DEPTH (POINTS)
	) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.re    (adv),
		.raddr (in_addr),
		.rdata (ram_rdata)
	);

	for (genvar k = 0; k < 3; k++) begin : g_lane
		ab5v_lane #(
			.W (W)
		) u_lane (
			.clk    (clk),
			.adv    (adv),
			.upd    (upd_s1),
			.dt     (dt_q),
			.gain   (gain_q),
			.value  (val_s1[k*W +: W]),
			.d0     (der_s1[k*W +: W]),
			.h1     (hist_rd[(0*3+k)*W +: W]),
			.h2     (hist_rd[(1*3+k)*W +: W]),
			.h3     (hist_rd[(2*3+k)*W +: W]),
			.h4     (hist_rd[(3*3+k)*W +: W]),
			.result (res[k])
		);
	end

	always_comb begin
		m_tdata = '0;
		m_tdata[IB-1:0] = idx_s[LAST];
		for (int k = 0; k < 3; k++) begin
			m_tdata[IB + k*W +: W] = res[k];
		end
	end

	// The pipeline holds no item while the history is being swept.
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> (vld_s == '0))
		else $error("item in pipeline during history clear");

	// The sweep ends right after the last entry is written.
	a_clear_end: assert property (@(posedge clk) disable iff (!arst_n)
		(clr_q && clr_addr_q == AW'(POINTS - 1)) |=> !clr_q)
		else $error("history clear did not end on last entry");

	// Back-to-back update of one point must take the forwarded history.
	a_forward: assert property (@(posedge clk) disable iff (!arst_n)
		(item_we && in_acc && in_addr == addr_s1) |=> fwd_s1)
		else $error("missed history forward");

	// A stalled output keeps the whole pipeline frozen.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[LAST] && !m_tready) |=> $stable(vld_s))
		else $error("pipeline moved while output stalled");

endmodule

`default_nettype wire
